FILE: rtl/chds_pkg.sv
// ----------------------------------------------------------------------------
// chds_pkg
// Types, constants and arithmetic helpers for the cosine hemisphere sampler.
// ----------------------------------------------------------------------------
package chds_pkg;

  localparam int VEC_FRAC = 15;
  localparam int IFRAC    = 30;

  localparam logic [31:0] ONE_Q30     = 32'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] SOLID_MAX   = 32'd67108863;
  // pi * 2^16, the smallest estimate (zeta_radial = 0)
  localparam logic [25:0] SOLID_MIN   = 26'd205887;

  // pipeline schedule: register stage index at which each step begins
  localparam int ST_TSQ       = 1;
  localparam int ST_NORM      = 2;
  localparam int ST_HORNER    = 3;
  localparam int HORNER_ITERS = 6;
  localparam int SIN_ITERS    = 5;
  localparam int ST_SIN       = ST_HORNER + 3 * HORNER_ITERS;
  localparam int ST_MAP       = ST_SIN + 1;
  localparam int SQ_STEPS     = 32;
  localparam int DIV_STEPS    = 32;
  localparam int ST_SQ1       = 3;
  localparam int ST_DIV1_INIT = ST_SQ1 + SQ_STEPS;
  localparam int ST_DIV1      = ST_DIV1_INIT + 1;
  localparam int ST_T         = ST_DIV1 + DIV_STEPS;
  localparam int ST_CROSS     = ST_T + 1;
  localparam int ST_CSQ       = ST_CROSS + 1;
  localparam int ST_CSUM      = ST_CSQ + 1;
  localparam int ST_SQ2       = ST_CSUM + 1;
  localparam int ST_DIV2_INIT = ST_SQ2 + SQ_STEPS;
  localparam int ST_DIV2      = ST_DIV2_INIT + 1;
  localparam int ST_B         = ST_DIV2 + DIV_STEPS;
  localparam int ST_PROD      = ST_B + 1;
  localparam int ST_OUT       = ST_PROD + 1;
  localparam int STAGES       = ST_OUT + 1;

  // Horner divisors; the sine chain has one term fewer (last entry unused)
  localparam logic [7:0] K_S [HORNER_ITERS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd2};
  localparam logic [7:0] K_C [HORNER_ITERS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [39:0] RECIP_S [HORNER_ITERS] = '{
    40'((64'd1 << 40) / 64'd110), 40'((64'd1 << 40) / 64'd72),
    40'((64'd1 << 40) / 64'd42),  40'((64'd1 << 40) / 64'd20),
    40'((64'd1 << 40) / 64'd6),   40'((64'd1 << 40) / 64'd2)};
  localparam logic [39:0] RECIP_C [HORNER_ITERS] = '{
    40'((64'd1 << 40) / 64'd132), 40'((64'd1 << 40) / 64'd90),
    40'((64'd1 << 40) / 64'd56),  40'((64'd1 << 40) / 64'd30),
    40'((64'd1 << 40) / 64'd12),  40'((64'd1 << 40) / 64'd2)};

  typedef struct packed {
    logic        [15:0] zeta_radial;
    logic        [15:0] zeta_angle;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic        [25:0] omega_est;
    logic               degenerate_up;
  } out_item_t;

  // bit-serial square root state
  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  // restoring divider state, 32 quotient bits
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [31:0] den;
  } dv_t;

  typedef struct packed {
    logic [2:0][15:0] u;
    logic             deg;
    logic [1:0]       quad;
    logic [2:0][17:0] tv;
    logic [2:0][33:0] tsq;
    sq_t              sa;
    sq_t              sb;
    sq_t              sc;
    logic [31:0]      x;
    logic [31:0]      x2;
    logic [33:0]      ts;
    logic [33:0]      tc;
    logic [31:0]      ps;
    logic [31:0]      pc;
    logic             ns;
    logic             nc;
    logic [31:0]      qs;
    logic [31:0]      qc;
    logic [31:0]      cs;
    logic [31:0]      sn;
    logic [31:0]      lx;
    logic [31:0]      ly;
    logic [30:0]      lz;
    dv_t [3:0]        dv;
    logic [2:0][31:0] tt;
    logic [2:0][33:0] cr;
    logic [2:0][63:0] csq;
    logic [2:0][31:0] bb;
    logic [25:0]      sol;
    logic [2:0][32:0] pt;
    logic [2:0][32:0] pb;
    logic [2:0][32:0] pu;
    logic [2:0][15:0] dir;
  } ctx_t;

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic [34:0] mag35(input logic signed [34:0] v);
    return v[34] ? 35'(-v) : 35'(v);
  endfunction

  // signed product, magnitude truncated by sh, sign applied afterwards
  function automatic logic signed [34:0] mulsh_q(input logic signed [33:0] a,
                                                 input logic signed [33:0] b,
                                                 input int sh);
    logic [67:0] p;
    logic [33:0] m;
    p = {34'b0, mag34(a)} * {34'b0, mag34(b)};
    m = 34'(p >> sh);
    return (a[33] != b[33]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [31:0] clamp_q30(input logic signed [33:0] v);
    logic [31:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b0, ONE_Q30})) begin
      r = ONE_Q30;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t         n;
    logic [35:0] t;
    logic [35:0] tr;
    n     = s;
    t     = {s.rem[33:0], s.rad[63:62]};
    tr    = {2'b0, s.root, 2'b01};
    n.rad = s.rad << 2;
    if (t >= tr) begin
      n.rem  = t - tr;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = t;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic dv_t dv_step(input dv_t s);
    dv_t         n;
    logic [32:0] t;
    n     = s;
    t     = {s.rem, s.low[31]};
    n.low = s.low << 1;
    if (t >= {1'b0, s.den}) begin
      n.rem = 32'(t - {1'b0, s.den});
      n.quo = {s.quo[30:0], 1'b1};
    end else begin
      n.rem = t[31:0];
      n.quo = {s.quo[30:0], 1'b0};
    end
    return n;
  endfunction

  function automatic dv_t dv_init(input logic [63:0] dvd, input logic [31:0] den);
    dv_t n;
    n.rem = dvd[63:32];
    n.low = dvd[31:0];
    n.quo = '0;
    n.den = den;
    return n;
  endfunction

endpackage

FILE: rtl/cosine_hemisphere_direction_sampler.sv
// ----------------------------------------------------------------------------
// cosine_hemisphere_direction_sampler
// Cosine-weighted hemisphere direction around an up vector, plus pi/cos.
// ----------------------------------------------------------------------------
// Fully pipelined: one item enters per clock unless the output is stalled; its
// result leaves from the last of STAGES registers (chds_pkg). The depth is set
// by the chain of bit-serial units: tangent-length square root, tangent divide,
// bitangent-length square root and bitangent divide, each 32 stages with one
// bit per stage. A stall at the output holds the whole pipeline; bubbles ahead
// of a stall do not collapse. zero_threshold is written through the cfg port,
// which is always ready, and takes effect for items accepted afterwards.
module cosine_hemisphere_direction_sampler
  import chds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [14:0] cfg_data
);

  logic [14:0]         zero_threshold_r;
  logic [STAGES-1:0]   vld_r;
  ctx_t                ctx_r [STAGES];
  ctx_t                ctx0_nxt;
  logic                adv;

  function automatic ctx_t stage_fn(input int k, input int j, input int sub,
                                    input ctx_t c);
    ctx_t               n;
    logic signed [34:0] pr;
    logic [39:0]        rem_s;
    logic [39:0]        rem_c;
    logic [71:0]        rp_s;
    logic [71:0]        rp_c;
    logic [31:0]        q_s;
    logic [31:0]        q_c;
    logic [31:0]        sv;
    logic [31:0]        cv;
    logic signed [17:0] tsh [3];
    logic [16:0]        tm;
    logic [33:0]        cm;
    logic [67:0]        sqp;
    logic signed [34:0] dsum;
    logic [34:0]        dm;
    logic [19:0]        rm;
    logic [63:0]        dvd;
    n = c;
    if (k == ST_TSQ) begin
      for (int i = 0; i < 3; i++) begin
        tm       = 17'(mag34(34'($signed(c.tv[i]))));
        n.tsq[i] = 34'(tm) * 34'(tm);
      end
      pr   = mulsh_q(34'(c.x), 34'(c.x), IFRAC);
      n.x2 = pr[31:0];
      n.ts = 34'(ONE_Q30);
      n.tc = 34'(ONE_Q30);
    end
    if (k == ST_NORM) begin
      n.sc.rad = 64'(c.tsq[0] + c.tsq[1] + c.tsq[2]) << 24;
    end
    if (k >= ST_HORNER && k < ST_SIN) begin
      case (sub)
        0: begin
          pr   = mulsh_q(34'(c.x2), $signed(mag34(c.ts)), IFRAC);
          n.ps = pr[31:0];
          n.ns = c.ts[33];
          pr   = mulsh_q(34'(c.x2), $signed(mag34(c.tc)), IFRAC);
          n.pc = pr[31:0];
          n.nc = c.tc[33];
        end
        1: begin
          rp_s = 72'(c.ps) * 72'(RECIP_S[j]);
          rp_c = 72'(c.pc) * 72'(RECIP_C[j]);
          n.qs = rp_s[71:40];
          n.qc = rp_c[71:40];
        end
        default: begin
          // reciprocal estimate is low by at most one
          rem_s = 40'(c.ps) - 40'(c.qs) * 40'(K_S[j]);
          rem_c = 40'(c.pc) - 40'(c.qc) * 40'(K_C[j]);
          q_s   = c.qs + 32'(rem_s >= 40'(K_S[j]));
          q_c   = c.qc + 32'(rem_c >= 40'(K_C[j]));
          if (j < SIN_ITERS) begin
            n.ts = c.ns ? 34'(ONE_Q30) + 34'(q_s) : 34'(ONE_Q30) - 34'(q_s);
          end
          n.tc = c.nc ? 34'(ONE_Q30) + 34'(q_c) : 34'(ONE_Q30) - 34'(q_c);
        end
      endcase
    end
    if (k == ST_SIN) begin
      pr   = mulsh_q(34'(c.x), $signed(c.ts), IFRAC);
      n.sn = pr[31:0];
    end
    if (k == ST_MAP) begin
      sv = clamp_q30(34'($signed(c.sn)));
      cv = clamp_q30($signed(c.tc));
      case (c.quad)
        2'd0:    begin n.cs = cv;      n.sn = sv;      end
        2'd1:    begin n.cs = 32'(-sv); n.sn = cv;      end
        2'd2:    begin n.cs = 32'(-cv); n.sn = 32'(-sv); end
        default: begin n.cs = sv;      n.sn = 32'(-cv); end
      endcase
    end
    if (k >= ST_SQ1 && k < ST_SQ1 + SQ_STEPS) begin
      n.sa = sq_step(c.sa);
      n.sb = sq_step(c.sb);
      n.sc = sq_step(c.sc);
    end
    if (k == ST_DIV1_INIT) begin
      pr   = mulsh_q(34'($signed(c.cs)), 34'(c.sa.root), IFRAC);
      n.lx = pr[31:0];
      pr   = mulsh_q(34'($signed(c.sn)), 34'(c.sa.root), IFRAC);
      n.ly = pr[31:0];
      n.lz = c.sb.root[30:0];
      for (int i = 0; i < 3; i++) begin
        tm       = 17'(mag34(34'($signed(c.tv[i]))));
        dvd      = {5'b0, tm, 42'b0};
        n.dv[i]  = dv_init(dvd, c.sc.root);
      end
      dvd     = {16'b0, PI_Q30, 16'b0} + {33'b0, c.sb.root[31:1]};
      n.dv[3] = dv_init(dvd, c.sb.root);
    end
    if (k >= ST_DIV1 && k < ST_DIV1 + DIV_STEPS) begin
      for (int i = 0; i < 4; i++) begin
        n.dv[i] = dv_step(c.dv[i]);
      end
    end
    if (k == ST_T) begin
      for (int i = 0; i < 3; i++) begin
        n.tt[i] = c.tv[i][17] ? 32'(-c.dv[i].quo) : c.dv[i].quo;
      end
      n.sol = (c.dv[3].quo > SOLID_MAX) ? 26'(SOLID_MAX) : c.dv[3].quo[25:0];
    end
    if (k == ST_CROSS) begin
      for (int i = 0; i < 3; i++) begin
        cm     = mag34(34'($signed(c.tt[i])));
        tsh[i] = c.tt[i][31] ? -$signed({1'b0, cm[31:15]}) : $signed({1'b0, cm[31:15]});
      end
      n.cr[0] = 34'($signed(c.u[1]) * tsh[2] - $signed(c.u[2]) * tsh[1]);
      n.cr[1] = 34'($signed(c.u[2]) * tsh[0] - $signed(c.u[0]) * tsh[2]);
      n.cr[2] = 34'($signed(c.u[0]) * tsh[1] - $signed(c.u[1]) * tsh[0]);
    end
    if (k == ST_CSQ) begin
      for (int i = 0; i < 3; i++) begin
        cm       = mag34($signed(c.cr[i]));
        sqp      = 68'(cm) * 68'(cm);
        n.csq[i] = sqp[63:0];
      end
    end
    if (k == ST_CSUM) begin
      n.sc.rad  = c.csq[0] + c.csq[1] + c.csq[2];
      n.sc.rem  = '0;
      n.sc.root = '0;
    end
    if (k >= ST_SQ2 && k < ST_SQ2 + SQ_STEPS) begin
      n.sc = sq_step(c.sc);
    end
    if (k == ST_DIV2_INIT) begin
      for (int i = 0; i < 3; i++) begin
        cm      = mag34($signed(c.cr[i]));
        dvd     = {1'b0, cm[32:0], 30'b0};
        n.dv[i] = dv_init(dvd, c.sc.root);
      end
    end
    if (k >= ST_DIV2 && k < ST_DIV2 + DIV_STEPS) begin
      for (int i = 0; i < 3; i++) begin
        n.dv[i] = dv_step(c.dv[i]);
      end
    end
    if (k == ST_B) begin
      for (int i = 0; i < 3; i++) begin
        if (c.sc.root == '0) begin
          n.bb[i] = '0;  // zero cross product: drop the bitangent
        end else begin
          n.bb[i] = c.cr[i][33] ? 32'(-c.dv[i].quo) : c.dv[i].quo;
        end
      end
    end
    if (k == ST_PROD) begin
      for (int i = 0; i < 3; i++) begin
        pr      = mulsh_q(34'($signed(c.tt[i])), 34'($signed(c.lx)), IFRAC);
        n.pt[i] = pr[32:0];
        pr      = mulsh_q(34'($signed(c.bb[i])), 34'($signed(c.ly)), IFRAC);
        n.pb[i] = pr[32:0];
        pr      = mulsh_q(34'($signed(c.u[i])), 34'(c.lz), VEC_FRAC);
        n.pu[i] = pr[32:0];
      end
    end
    if (k == ST_OUT) begin
      for (int i = 0; i < 3; i++) begin
        dsum = 35'($signed(c.pt[i])) + 35'($signed(c.pb[i])) + 35'($signed(c.pu[i]));
        dm   = mag35(dsum);
        rm   = 20'((dm + (35'd1 << (IFRAC - VEC_FRAC - 1))) >> (IFRAC - VEC_FRAC));
        if (c.deg) begin
          n.dir[i] = '0;
        end else if (dsum[34]) begin
          n.dir[i] = (rm > 20'd32768) ? 16'h8000 : 16'(-rm);
        end else begin
          n.dir[i] = (rm > 20'd32767) ? 16'h7fff : rm[15:0];
        end
      end
    end
    return n;
  endfunction

  // stage 0: tangent choice, angle scaling, square-root radicands
  always_comb begin
    logic [16:0]        m [3];
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [17:0] t0;
    logic signed [17:0] t1;
    logic signed [17:0] t2;
    logic [44:0]        xp;
    logic [16:0]        omr;
    ctx0_nxt = '0;
    ux = in_data.up_x;
    uy = in_data.up_y;
    uz = in_data.up_z;
    ctx0_nxt.u[0] = ux;
    ctx0_nxt.u[1] = uy;
    ctx0_nxt.u[2] = uz;
    m[0] = 17'(mag34(34'(ux)));
    m[1] = 17'(mag34(34'(uy)));
    m[2] = 17'(mag34(34'(uz)));
    ctx0_nxt.deg = 1'b0;
    if (m[0] > {2'b0, zero_threshold_r}) begin
      t0 = -18'(uy) - 18'(uz);
      t1 = 18'(ux);
      t2 = 18'(ux);
      if (ux < 0) begin
        t0 = -t0; t1 = -t1; t2 = -t2;
      end
    end else if (m[1] > {2'b0, zero_threshold_r}) begin
      t0 = 18'(uy);
      t1 = -18'(ux) - 18'(uz);
      t2 = 18'(uy);
      if (uy < 0) begin
        t0 = -t0; t1 = -t1; t2 = -t2;
      end
    end else if (m[2] > {2'b0, zero_threshold_r}) begin
      t0 = 18'(uz);
      t1 = 18'(uz);
      t2 = -18'(ux) - 18'(uy);
      if (uz < 0) begin
        t0 = -t0; t1 = -t1; t2 = -t2;
      end
    end else begin
      t0 = '0; t1 = '0; t2 = '0;
      ctx0_nxt.deg = 1'b1;
    end
    ctx0_nxt.tv[0] = t0;
    ctx0_nxt.tv[1] = t1;
    ctx0_nxt.tv[2] = t2;
    ctx0_nxt.quad  = in_data.zeta_angle[15:14];
    xp             = 45'(in_data.zeta_angle[13:0]) * 45'(HALF_PI_Q30);
    ctx0_nxt.x     = 32'(xp >> 14);
    omr            = 17'd65536 - 17'(in_data.zeta_radial);
    ctx0_nxt.sa.rad = {4'b0, in_data.zeta_radial, 44'b0};
    ctx0_nxt.sb.rad = {3'b0, omr, 44'b0};
  end

  // one global advance: the pipeline moves unless the output item is held
  assign adv       = !vld_r[STAGES-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_threshold_r <= '0;
    end else if (cfg_valid) begin
      zero_threshold_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[0] <= ctx0_nxt;
    end
  end

  for (genvar g = 1; g < STAGES; g++) begin : g_stage
    localparam int HJ  = (g >= ST_HORNER) ? (g - ST_HORNER) / 3 : 0;
    localparam int SUB = (g >= ST_HORNER) ? (g - ST_HORNER) % 3 : 0;
    always_ff @(posedge clk) begin
      if (adv) begin
        ctx_r[g] <= stage_fn(g, (HJ < HORNER_ITERS) ? HJ : 0, SUB, ctx_r[g-1]);
      end
    end
  end

  assign out_valid              = vld_r[STAGES-1];
  assign out_data.dir_x         = ctx_r[STAGES-1].dir[0];
  assign out_data.dir_y         = ctx_r[STAGES-1].dir[1];
  assign out_data.dir_z         = ctx_r[STAGES-1].dir[2];
  assign out_data.omega_est     = ctx_r[STAGES-1].sol;
  assign out_data.degenerate_up = ctx_r[STAGES-1].deg;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate_up |->
      out_data.dir_x == 16'sd0 && out_data.dir_y == 16'sd0 && out_data.dir_z == 16'sd0)
    else $error("degenerate up item carries a nonzero direction");

  a_sol_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.omega_est >= SOLID_MIN)
    else $error("solid angle estimate below pi");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held result item changed");

endmodule
